>>> hw/rtl/dbfd_pkg.sv
// Shared types, constants and register codes for the detection box filter decoder.
package dbfd_pkg;

	localparam int MAX_ATTR = 256;
	localparam int POS_W = $clog2(MAX_ATTR + 1);
	localparam int IDX_W = $clog2(MAX_ATTR);
	localparam int VAL_W = 18;
	localparam int NUM_CLS = 5;
	localparam int CLS_W = 3;
	localparam int THR_W = 16;
	localparam int FRAME_W = 12;
	localparam int OUT_W = 16;
	localparam int DATA_W = 16;
	localparam int FIRST_CLS_POS = 5;
	localparam int MIN_ATTR = 6;
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [THR_W-1:0] OBJ_DEFAULT_THR = 16'd16384;
	localparam logic [THR_W-1:0] THR_RESET = 16'd16384;
	localparam logic [CLS_W-1:0] CLASSES_RESET = 3'd5;
	localparam logic [FRAME_W-1:0] FRAME_RESET = 12'd640;

	typedef enum logic [2:0] {
		REG_CLASSES = 3'd0,
		REG_THR0    = 3'd1,
		REG_THR1    = 3'd2,
		REG_THR2    = 3'd3,
		REG_THR3    = 3'd4,
		REG_THR4    = 3'd5,
		REG_FRAME_W = 3'd6,
		REG_FRAME_H = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] cx;
		logic signed [VAL_W-1:0] cy;
		logic signed [VAL_W-1:0] w;
		logic signed [VAL_W-1:0] h;
		logic signed [VAL_W-1:0] obj;
		logic signed [VAL_W-1:0] best;
		logic [IDX_W-1:0]        bidx;
	} rec_t;

	typedef struct packed {
		logic [CLS_W-1:0]               classes;
		logic [NUM_CLS-1:0][THR_W-1:0]  thr;
		logic [FRAME_W-1:0]             fw;
		logic [FRAME_W-1:0]             fh;
	} cfg_t;

endpackage

>>> hw/rtl/dbfd_if.sv
// Handshake channels for attribute beats and for decoded box beats.
interface dbfd_attr_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [dbfd_pkg::VAL_W-1:0]      attribute_value;
	logic                                   box_end;

	modport source(output valid, output attribute_value, output box_end, input ready);
	modport sink(input valid, input attribute_value, input box_end, output ready);
endinterface

interface dbfd_det_if;
	logic                           valid;
	logic                           ready;
	logic [dbfd_pkg::CLS_W-1:0]     class_id;
	logic [dbfd_pkg::OUT_W-1:0]     confidence;
	logic [dbfd_pkg::OUT_W-1:0]     box_left;
	logic [dbfd_pkg::OUT_W-1:0]     box_top;
	logic [dbfd_pkg::OUT_W-1:0]     box_width;
	logic [dbfd_pkg::OUT_W-1:0]     box_height;

	modport source(output valid, output class_id, output confidence, output box_left,
		output box_top, output box_width, output box_height, input ready);
	modport sink(input valid, input class_id, input confidence, input box_left,
		input box_top, input box_width, input box_height, output ready);
endinterface

>>> hw/rtl/dbfd_front.sv
// Front end: gathers one box record from attribute beats and keeps the running argmax.
module dbfd_front (
	input  logic             clk,
	input  logic             arst_n,
	dbfd_attr_if.sink        attr,
	input  logic             full,
	output logic             push,
	output dbfd_pkg::rec_t   rec
);

	logic [dbfd_pkg::POS_W-1:0] pos_q;
	logic [dbfd_pkg::POS_W-1:0] cnt_n;
	dbfd_pkg::rec_t             rec_q;
	dbfd_pkg::rec_t             rec_n;
	logic                       acc;

	assign attr.ready = !full;
	assign acc = attr.valid && attr.ready;

	always_comb begin
		rec_n = rec_q;
		cnt_n = pos_q;
		if (pos_q < dbfd_pkg::POS_W'(dbfd_pkg::MAX_ATTR)) begin
			cnt_n = pos_q + dbfd_pkg::POS_W'(1);
			if (pos_q == dbfd_pkg::POS_W'(0)) begin
				rec_n.cx = attr.attribute_value;
			end else if (pos_q == dbfd_pkg::POS_W'(1)) begin
				rec_n.cy = attr.attribute_value;
			end else if (pos_q == dbfd_pkg::POS_W'(2)) begin
				rec_n.w = attr.attribute_value;
			end else if (pos_q == dbfd_pkg::POS_W'(3)) begin
				rec_n.h = attr.attribute_value;
			end else if (pos_q == dbfd_pkg::POS_W'(4)) begin
				rec_n.obj = attr.attribute_value;
			end else if (pos_q == dbfd_pkg::POS_W'(dbfd_pkg::FIRST_CLS_POS)) begin
				rec_n.best = attr.attribute_value;
				rec_n.bidx = '0;
			end else if (attr.attribute_value > rec_q.best) begin
				rec_n.best = attr.attribute_value;
				rec_n.bidx = dbfd_pkg::IDX_W'(pos_q - dbfd_pkg::POS_W'(dbfd_pkg::FIRST_CLS_POS));
			end
		end
	end

	assign push = acc && attr.box_end && (cnt_n >= dbfd_pkg::POS_W'(dbfd_pkg::MIN_ATTR));
	assign rec = rec_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			pos_q <= attr.box_end ? '0 : cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rec_q <= rec_n;
		end
	end

endmodule

>>> hw/rtl/dbfd_queue.sv
// Short record queue between the front end and the box math.
module dbfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dbfd_pkg::rec_t   push_rec,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output dbfd_pkg::rec_t   head
);

	dbfd_pkg::rec_t               mem_q [dbfd_pkg::Q_DEPTH];
	logic [dbfd_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [dbfd_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [dbfd_pkg::Q_CNT_W-1:0] cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full = (cnt_q == dbfd_pkg::Q_CNT_W'(dbfd_pkg::Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + dbfd_pkg::Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + dbfd_pkg::Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + dbfd_pkg::Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - dbfd_pkg::Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

>>> hw/rtl/dbfd_back.sv
// Back end: filters a record, scales and clips the box, and holds the result beat.
module dbfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  dbfd_pkg::cfg_t   cfg,
	input  logic             head_valid,
	input  dbfd_pkg::rec_t   head,
	output logic             pop,
	dbfd_det_if.source       det
);

	localparam int MUL_W = dbfd_pkg::VAL_W + 2 + dbfd_pkg::FRAME_W + 1;
	localparam int PROD_W = 2 * dbfd_pkg::VAL_W;
	localparam int CLIP_W = MUL_W + 1;
	localparam int FINE_SHIFT = 13;
	localparam int EDGE_SHIFT = 17;
	localparam int EDGE_PAD = CLIP_W - dbfd_pkg::FRAME_W - EDGE_SHIFT;
	localparam int SAT_HI = FINE_SHIFT + dbfd_pkg::OUT_W;

	typedef struct packed {
		logic                        ok;
		logic [dbfd_pkg::OUT_W-1:0]  start;
		logic [dbfd_pkg::OUT_W-1:0]  len;
	} axis_t;

	function automatic axis_t clip_axis(input logic signed [MUL_W-1:0] start,
			input logic signed [MUL_W-1:0] len, input logic [dbfd_pkg::FRAME_W-1:0] frame);
		logic signed [CLIP_W-1:0] s;
		logic signed [CLIP_W-1:0] n;
		logic signed [CLIP_W-1:0] lim;
		axis_t r;
		s = start[MUL_W-1] ? '0 : {start[MUL_W-1], start};
		n = {len[MUL_W-1], len};
		lim = $signed({{EDGE_PAD{1'b0}}, frame, {EDGE_SHIFT{1'b0}}});
		if (s + n > lim) begin
			n = lim - s;
		end
		r.ok = (n >= $signed(CLIP_W'(1) << FINE_SHIFT));
		r.start = (|s[CLIP_W-1:SAT_HI]) ? '1 : s[SAT_HI-1:FINE_SHIFT];
		r.len = (|n[CLIP_W-1:SAT_HI]) ? '1 : n[SAT_HI-1:FINE_SHIFT];
		return r;
	endfunction

	logic                              adv;
	logic [dbfd_pkg::CLS_W-1:0]        nclass;
	logic [dbfd_pkg::THR_W-1:0]        obj_thr;
	logic                              obj_ok;
	logic                              cls_ok;
	logic signed [dbfd_pkg::VAL_W+1:0] dx;
	logic signed [dbfd_pkg::VAL_W+1:0] dy;
	logic signed [dbfd_pkg::VAL_W+1:0] w2;
	logic signed [dbfd_pkg::VAL_W+1:0] h2;
	logic signed [dbfd_pkg::FRAME_W:0] fw_s;
	logic signed [dbfd_pkg::FRAME_W:0] fh_s;

	logic                              vld_s1;
	logic                              keep_s1;
	logic [dbfd_pkg::CLS_W-1:0]        cls_s1;
	logic [dbfd_pkg::THR_W-1:0]        thr_s1;
	logic signed [PROD_W-1:0]          prod_s1;
	logic signed [MUL_W-1:0]           l_s1;
	logic signed [MUL_W-1:0]           t_s1;
	logic signed [MUL_W-1:0]           wd_s1;
	logic signed [MUL_W-1:0]           hd_s1;

	logic                              conf_ok;
	axis_t                             ax;
	axis_t                             ay;

	logic                              valid_q;
	logic [dbfd_pkg::CLS_W-1:0]        class_q;
	logic [dbfd_pkg::OUT_W-1:0]        conf_q;
	logic [dbfd_pkg::OUT_W-1:0]        left_q;
	logic [dbfd_pkg::OUT_W-1:0]        top_q;
	logic [dbfd_pkg::OUT_W-1:0]        width_q;
	logic [dbfd_pkg::OUT_W-1:0]        height_q;

	assign adv = !valid_q || det.ready;
	assign pop = adv && head_valid;

	assign nclass = (cfg.classes > dbfd_pkg::CLS_W'(dbfd_pkg::NUM_CLS)) ?
		dbfd_pkg::CLS_W'(dbfd_pkg::NUM_CLS) : cfg.classes;
	assign obj_thr = (nclass != '0 && cfg.thr[0] != '0) ? cfg.thr[0] : dbfd_pkg::OBJ_DEFAULT_THR;
	assign obj_ok = !head.obj[dbfd_pkg::VAL_W-1] &&
		(head.obj[dbfd_pkg::VAL_W-2:0] >= {1'b0, obj_thr});
	assign cls_ok = head.bidx < dbfd_pkg::IDX_W'(nclass);

	assign dx = $signed({head.cx[dbfd_pkg::VAL_W-1], head.cx, 1'b0}) -
		$signed({{2{head.w[dbfd_pkg::VAL_W-1]}}, head.w});
	assign dy = $signed({head.cy[dbfd_pkg::VAL_W-1], head.cy, 1'b0}) -
		$signed({{2{head.h[dbfd_pkg::VAL_W-1]}}, head.h});
	assign w2 = $signed({head.w[dbfd_pkg::VAL_W-1], head.w, 1'b0});
	assign h2 = $signed({head.h[dbfd_pkg::VAL_W-1], head.h, 1'b0});
	assign fw_s = $signed({1'b0, cfg.fw});
	assign fh_s = $signed({1'b0, cfg.fh});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			keep_s1 <= obj_ok && cls_ok;
			cls_s1 <= head.bidx[dbfd_pkg::CLS_W-1:0];
			thr_s1 <= cls_ok ? cfg.thr[head.bidx[dbfd_pkg::CLS_W-1:0]] : '0;
			prod_s1 <= head.obj * head.best;
			l_s1 <= dx * fw_s;
			t_s1 <= dy * fh_s;
			wd_s1 <= w2 * fw_s;
			hd_s1 <= h2 * fh_s;
		end
	end

	assign conf_ok = !prod_s1[PROD_W-1] &&
		(prod_s1[PROD_W-2:0] >= {3'b000, thr_s1, 16'h0000});
	assign ax = clip_axis(l_s1, wd_s1, cfg.fw);
	assign ay = clip_axis(t_s1, hd_s1, cfg.fh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= vld_s1 && keep_s1 && conf_ok && ax.ok && ay.ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			class_q <= cls_s1;
			conf_q <= (|prod_s1[PROD_W-2:32]) ? '1 : prod_s1[31:16];
			left_q <= ax.start;
			top_q <= ay.start;
			width_q <= ax.len;
			height_q <= ay.len;
		end
	end

	assign det.valid = valid_q;
	assign det.class_id = class_q;
	assign det.confidence = conf_q;
	assign det.box_left = left_q;
	assign det.box_top = top_q;
	assign det.box_width = width_q;
	assign det.box_height = height_q;

endmodule

>>> hw/rtl/detection_box_filter_decode_top.sv
// Top level of the detection box filter decoder: configuration registers and the three parts.
//
//   Channel   Role     Beat
//   attr      sink     one Q2.16 attribute, box_end on the last one of a record
//   det       source   one decoded box: class, confidence, Q12.4 left/top/width/height
//   wr_*      write    register index and data, taken whenever wr_en is high
//
// One attribute beat is taken every cycle while the record queue has room.
// A passing box shows on det once its closing record has gone through the record
// queue, the multiply stage and the output register.
// A stall on det holds the math stages; the two-entry queue then fills and
// drops attr.ready. Reset clears the record position, queue and valid flags.
module detection_box_filter_decode_top (
	input  logic                           clk,
	input  logic                           arst_n,
	dbfd_attr_if.sink                      attr,
	dbfd_det_if.source                     det,
	input  logic                           wr_en,
	input  logic [2:0]                     wr_index,
	input  logic [dbfd_pkg::DATA_W-1:0]    wr_data
);

	dbfd_pkg::cfg_t cfg_q;
	dbfd_pkg::rec_t front_rec;
	dbfd_pkg::rec_t head;
	logic           push;
	logic           full;
	logic           pop;
	logic           head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.classes <= dbfd_pkg::CLASSES_RESET;
			cfg_q.thr <= {dbfd_pkg::NUM_CLS{dbfd_pkg::THR_RESET}};
			cfg_q.fw <= dbfd_pkg::FRAME_RESET;
			cfg_q.fh <= dbfd_pkg::FRAME_RESET;
		end else if (wr_en) begin
			case (dbfd_pkg::reg_idx_t'(wr_index))
				dbfd_pkg::REG_CLASSES: begin
					cfg_q.classes <= wr_data[dbfd_pkg::CLS_W-1:0];
				end
				dbfd_pkg::REG_THR0: begin
					cfg_q.thr[0] <= wr_data;
				end
				dbfd_pkg::REG_THR1: begin
					cfg_q.thr[1] <= wr_data;
				end
				dbfd_pkg::REG_THR2: begin
					cfg_q.thr[2] <= wr_data;
				end
				dbfd_pkg::REG_THR3: begin
					cfg_q.thr[3] <= wr_data;
				end
				dbfd_pkg::REG_THR4: begin
					cfg_q.thr[4] <= wr_data;
				end
				dbfd_pkg::REG_FRAME_W: begin
					cfg_q.fw <= wr_data[dbfd_pkg::FRAME_W-1:0];
				end
				dbfd_pkg::REG_FRAME_H: begin
					cfg_q.fh <= wr_data[dbfd_pkg::FRAME_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	dbfd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.attr   (attr),
		.full   (full),
		.push   (push),
		.rec    (front_rec)
	);

	dbfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (front_rec),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	dbfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.det        (det)
	);

endmodule

>>> bench/tb_detection_box_filter_decode_top.sv
// Self-checking testbench for the detection box filter decoder with a predicting scoreboard.
module tb_detection_box_filter_decode_top;
	import dbfd_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int FINE_TO_Q4 = 13;
	localparam int LONG_STALL_CYCLES = 150;
	localparam int NUM_SETTINGS = 8;
	localparam int PHASE_ITEMS = 190;

	typedef struct packed {
		logic [CLS_W-1:0] class_id;
		logic [OUT_W-1:0] confidence;
		logic [OUT_W-1:0] box_left;
		logic [OUT_W-1:0] box_top;
		logic [OUT_W-1:0] box_width;
		logic [OUT_W-1:0] box_height;
	} det_box_t;

	typedef logic signed [VAL_W-1:0] attr_q_t [$];

	typedef enum {RX_ALWAYS, RX_RANDOM, RX_SLOW} rx_mode_t;

	class box_scoreboard;
		logic [CLS_W-1:0] n_classes;
		logic [THR_W-1:0] thr [NUM_CLS];
		logic [FRAME_W-1:0] fw;
		logic [FRAME_W-1:0] fh;
		int unsigned pos;
		int cx;
		int cy;
		int bw;
		int bh;
		int obj;
		int best;
		int unsigned best_idx;
		det_box_t expected_q [$];
		int errors;

		function new();
			n_classes = CLASSES_RESET;
			foreach (thr[i]) thr[i] = THR_RESET;
			fw = FRAME_RESET;
			fh = FRAME_RESET;
			errors = 0;
			clear_record();
		endfunction

		function void clear_record();
			pos = 0;
			cx = 0;
			cy = 0;
			bw = 0;
			bh = 0;
			obj = 0;
			best = 0;
			best_idx = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [DATA_W-1:0] d);
			case (idx)
			REG_CLASSES: n_classes = d[CLS_W-1:0];
			REG_THR0: thr[0] = d[THR_W-1:0];
			REG_THR1: thr[1] = d[THR_W-1:0];
			REG_THR2: thr[2] = d[THR_W-1:0];
			REG_THR3: thr[3] = d[THR_W-1:0];
			REG_THR4: thr[4] = d[THR_W-1:0];
			REG_FRAME_W: fw = d[FRAME_W-1:0];
			REG_FRAME_H: fh = d[FRAME_W-1:0];
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function bit fit_axis(longint start, longint len, longint edge_fine,
			output logic [OUT_W-1:0] q_start, output logic [OUT_W-1:0] q_len);
			longint s;
			longint n;
			longint qs;
			longint ql;
			q_start = '0;
			q_len = '0;
			s = (start < 0) ? 0 : start;
			n = len;
			if (s + n > edge_fine) n = edge_fine - s;
			if (n <= 0) return 1'b0;
			ql = n >>> FINE_TO_Q4;
			if (ql <= 0) return 1'b0;
			qs = s >>> FINE_TO_Q4;
			if (qs > 65535) qs = 65535;
			if (ql > 65535) ql = 65535;
			q_start = qs[OUT_W-1:0];
			q_len = ql[OUT_W-1:0];
			return 1'b1;
		endfunction

		function bit decode_box(output det_box_t b);
			int unsigned nk;
			longint obj_thr;
			longint cls_thr;
			longint prod;
			longint conf;
			longint wf;
			longint hf;
			b = '0;
			if (pos < MIN_ATTR) return 1'b0;
			nk = (n_classes > NUM_CLS) ? NUM_CLS : n_classes;
			obj_thr = (nk > 0 && thr[0] > 0) ? thr[0] : OBJ_DEFAULT_THR;
			if (longint'(obj) < obj_thr) return 1'b0;
			if (best_idx >= nk) return 1'b0;
			prod = longint'(obj) * longint'(best);
			if (prod < 0) return 1'b0;
			cls_thr = thr[best_idx];
			if (prod < cls_thr * 65536) return 1'b0;
			wf = fw;
			hf = fh;
			if (!fit_axis((longint'(cx) * 2 - bw) * wf, longint'(bw) * 2 * wf, wf * 131072,
				b.box_left, b.box_width)) return 1'b0;
			if (!fit_axis((longint'(cy) * 2 - bh) * hf, longint'(bh) * 2 * hf, hf * 131072,
				b.box_top, b.box_height)) return 1'b0;
			conf = prod >>> 16;
			if (conf > 65535) conf = 65535;
			b.class_id = CLS_W'(best_idx);
			b.confidence = conf[OUT_W-1:0];
			return 1'b1;
		endfunction

		function void note_attr(logic signed [VAL_W-1:0] v, bit last);
			det_box_t b;
			int sv;
			sv = int'(v);
			if (pos < MAX_ATTR) begin
				case (pos)
				0: cx = sv;
				1: cy = sv;
				2: bw = sv;
				3: bh = sv;
				4: obj = sv;
				FIRST_CLS_POS: begin
					best = sv;
					best_idx = 0;
				end
				default: begin
					if (sv > best) begin
						best = sv;
						best_idx = pos - FIRST_CLS_POS;
					end
				end
				endcase
				pos++;
			end
			if (last) begin
				if (decode_box(b)) expected_q.insert(expected_q.size(), b);
				clear_record();
			end
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		function void check(det_box_t got);
			det_box_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected box beat, expected none, actual class %0d conf %0d",
					$time, got.class_id, got.confidence);
				return;
			end
			want = expected_q.pop_front();
			compare_field("class_id", want.class_id, got.class_id);
			compare_field("confidence", want.confidence, got.confidence);
			compare_field("box_left", want.box_left, got.box_left);
			compare_field("box_top", want.box_top, got.box_top);
			compare_field("box_width", want.box_width, got.box_width);
			compare_field("box_height", want.box_height, got.box_height);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [DATA_W-1:0] wr_data;

	dbfd_attr_if attr();
	dbfd_det_if det();

	detection_box_filter_decode_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.attr(attr),
		.det(det),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	box_scoreboard boxes;
	bit attr_up;
	int burst_left;
	int items_sent;
	bit long_stall_go;
	int cycles;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		rx_mode_t rx_mode;
		int mode_left;
		int stall_left;
		det_box_t got;
		det.ready <= 1'b0;
		rx_mode = RX_ALWAYS;
		mode_left = 0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && det.valid && det.ready) begin
				got.class_id = det.class_id;
				got.confidence = det.confidence;
				got.box_left = det.box_left;
				got.box_top = det.box_top;
				got.box_width = det.box_width;
				got.box_height = det.box_height;
				boxes.check(got);
			end
			if (long_stall_go) begin
				stall_left = LONG_STALL_CYCLES;
				long_stall_go = 1'b0;
			end
			if (stall_left > 0) begin
				stall_left--;
				det.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 200);
				end else begin
					mode_left--;
				end
				case (rx_mode)
				RX_ALWAYS: det.ready <= 1'b1;
				RX_RANDOM: det.ready <= 1'($urandom_range(0, 1));
				RX_SLOW: det.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic put_attr(input logic signed [VAL_W-1:0] v, input bit last);
		attr.valid <= 1'b1;
		attr.attribute_value <= v;
		attr.box_end <= last;
		attr_up = 1'b1;
		do @(posedge clk); while (!attr.ready);
		boxes.note_attr(v, last);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			attr.valid <= 1'b0;
			attr_up = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120) :
				$urandom_range(0, 10);
		end
	endtask

	task automatic send_record(input attr_q_t vals);
		foreach (vals[i]) put_attr(vals[i], i == vals.size() - 1);
	endtask

	task automatic drain_boxes();
		if (attr_up) begin
			attr.valid <= 1'b0;
			attr_up = 1'b0;
		end
		while (boxes.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] rand_coord();
		int t;
		case ($urandom_range(0, 7))
		0: begin
			t = $urandom_range(0, 20000);
			return VAL_W'(-t);
		end
		1: return VAL_W'(65536 + $urandom_range(0, 20000));
		default: return VAL_W'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_size();
		int t;
		case ($urandom_range(0, 9))
		0: begin
			t = $urandom_range(0, 3000);
			return VAL_W'(-t);
		end
		1: return VAL_W'($urandom_range(1, 64));
		default: return VAL_W'($urandom_range(100, 60000));
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_obj();
		int t;
		case ($urandom_range(0, 9))
		0: begin
			t = $urandom_range(1, 131072);
			return VAL_W'(-t);
		end
		1: return VAL_W'(OBJ_DEFAULT_THR - $urandom_range(0, 1));
		2: return VAL_W'(boxes.thr[0]);
		default: return VAL_W'($urandom_range(12000, 131071));
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_score();
		int t;
		case ($urandom_range(0, 9))
		0: begin
			t = $urandom_range(1, 131072);
			return VAL_W'(-t);
		end
		1: return VAL_W'(131071);
		default: return VAL_W'($urandom_range(0, 90000));
		endcase
	endfunction

	task automatic send_box();
		attr_q_t vals;
		logic signed [VAL_W-1:0] s;
		vals.insert(vals.size(), rand_coord());
		vals.insert(vals.size(), rand_coord());
		vals.insert(vals.size(), rand_size());
		vals.insert(vals.size(), rand_size());
		vals.insert(vals.size(), rand_obj());
		repeat ($urandom_range(1, 6)) begin
			if (vals.size() > FIRST_CLS_POS && $urandom_range(0, 3) == 0)
				s = vals[vals.size() - 1];
			else
				s = rand_score();
			vals.insert(vals.size(), s);
		end
		send_record(vals);
	endtask

	task automatic send_noise(input int len);
		logic signed [VAL_W-1:0] v;
		for (int i = 0; i < len; i++) begin
			v = VAL_W'($urandom);
			put_attr(v, (i == len - 1) || ($urandom_range(0, 5) == 0));
		end
	endtask

	task automatic send_short();
		attr_q_t vals;
		int len;
		len = $urandom_range(1, MIN_ATTR - 1);
		vals.insert(vals.size(), rand_coord());
		vals.insert(vals.size(), rand_coord());
		vals.insert(vals.size(), rand_size());
		vals.insert(vals.size(), rand_size());
		vals.insert(vals.size(), rand_obj());
		while (vals.size() > len) void'(vals.pop_back());
		send_record(vals);
	endtask

	task automatic send_long();
		attr_q_t vals;
		vals = '{32768, 32768, 16384, 16384, 65536, 50000};
		while (vals.size() < MAX_ATTR) vals.insert(vals.size(), VAL_W'($urandom_range(0, 49999)));
		repeat (8) vals.insert(vals.size(), VAL_W'(131071));
		send_record(vals);
	endtask

	task automatic run_random(input int target);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) send_box();
			else if (pick < 18) send_noise($urandom_range(1, 12));
			else send_short();
		end
	endtask

	task automatic apply_setting(input int p);
		logic [DATA_W-1:0] v [8];
		v[REG_CLASSES] = DATA_W'(NUM_CLS);
		for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = DATA_W'($urandom_range(0, 30000));
		v[REG_FRAME_W] = DATA_W'($urandom_range(1, 4095));
		v[REG_FRAME_H] = DATA_W'($urandom_range(1, 4095));
		case (p)
		0: begin
			v[REG_CLASSES] = DATA_W'(0);
			for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = THR_RESET;
			v[REG_FRAME_W] = DATA_W'(640);
			v[REG_FRAME_H] = DATA_W'(480);
		end
		1: begin
			for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = DATA_W'(0);
			v[REG_FRAME_W] = DATA_W'(4095);
			v[REG_FRAME_H] = DATA_W'(4095);
		end
		2: begin
			v[REG_CLASSES] = DATA_W'(1);
			v[REG_THR0] = DATA_W'(65535);
			v[REG_FRAME_W] = DATA_W'(1);
			v[REG_FRAME_H] = DATA_W'(1);
		end
		3: begin
			v[REG_CLASSES] = DATA_W'(7);
			for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = DATA_W'($urandom_range(0, 8000));
		end
		4: begin
			v[REG_CLASSES] = DATA_W'(3);
			v[REG_FRAME_W] = DATA_W'(4095);
			v[REG_FRAME_H] = DATA_W'(1);
		end
		5: begin
			v[REG_CLASSES] = DATA_W'(2);
			v[REG_THR0] = DATA_W'(1);
			v[REG_THR1] = DATA_W'(65535);
			v[REG_FRAME_W] = DATA_W'(1920);
			v[REG_FRAME_H] = DATA_W'(1080);
		end
		6: begin
			for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = DATA_W'($urandom_range(0, 65535));
		end
		default: begin
			v[REG_CLASSES] = DATA_W'(4);
			for (int k = 0; k < NUM_CLS; k++) v[REG_THR0 + k] = DATA_W'(8192);
			v[REG_FRAME_W] = DATA_W'(416);
			v[REG_FRAME_H] = DATA_W'(416);
		end
		endcase
		for (int i = 0; i < 8; i++) begin
			wr_en <= 1'b1;
			wr_index <= reg_idx_t'(i);
			wr_data <= v[i];
			@(posedge clk);
			boxes.write_reg(reg_idx_t'(i), v[i]);
		end
		wr_en <= 1'b0;
	endtask

	initial begin
		attr_q_t vals;
		boxes = new();
		attr_up = 1'b0;
		burst_left = 0;
		items_sent = 0;
		long_stall_go = 1'b0;
		cycles = 0;
		arst_n <= 1'b0;
		attr.valid <= 1'b0;
		attr.attribute_value <= '0;
		attr.box_end <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_CLASSES;
		wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Tie between the first two classes, box hanging over the top left corner.
		vals = '{0, 0, 32768, 32768, 65536, 40000, 40000};
		send_record(vals);
		// Full-scale record: confidence saturates and the box fills the frame.
		vals = '{32768, 32768, 131071, 131071, 131071, 131071};
		send_record(vals);
		vals = '{-131072, -131072, -131072};
		send_record(vals);
		// Best class is the last one after a most-negative first score.
		vals = '{40000, 30000, 20000, 20000, 131071, -131072, 5000, 6000, 7000, 60000};
		send_record(vals);
		drain_boxes();

		for (int p = 0; p < NUM_SETTINGS; p++) begin
			apply_setting(p);
			if (p == 2 || p == 5) long_stall_go = 1'b1;
			if (p == 1) send_long();
			run_random(PHASE_ITEMS);
			drain_boxes();
		end

		if (boxes.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
